/* sv/sid_pkg.sv */
// Shared types, widths and the microcode ROM for the step interval distributor.
// Used by every module of the block; depends on nothing.
package sid_pkg;

    localparam int POS_W     = 24;   // positions and step counts
    localparam int TICK_W    = 31;   // tick budget and intervals
    localparam int ERR_W     = 34;   // signed Bresenham error term
    localparam int PC_W      = 4;    // microcode address
    localparam int DIV_CNT_W = $clog2(TICK_W);

    // Configuration register indexes
    localparam logic CFG_MAX_POS = 1'b0;
    localparam logic CFG_TICKS   = 1'b1;

    // Request types
    localparam logic REQ_START = 1'b0;

    localparam logic [POS_W-1:0]  MAX_POS_RST = {POS_W{1'b1}};
    localparam logic [TICK_W-1:0] TICKS_RST   = TICK_W'(240000000);

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_FETCH  = 4'd1,   // take an input word, clear result flags
        OP_START  = 4'd2,   // queued position and segment target <= start position
        OP_PLAN   = 4'd3,   // launch divider: budget / step count
        OP_COMMIT = 4'd4,   // store the new plan
        OP_ACCUM  = 4'd5,   // error += 2 * extra
        OP_EMIT   = 4'd6,   // compare, correct error, produce interval
        OP_PERR   = 4'd7,   // flag plan error
        OP_END    = 4'd8,   // flag end of travel
        OP_OUT    = 4'd9    // move result into the output register
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_ITEM  = 3'd2,
        C_IS_START = 3'd3,
        C_AT_END   = 3'd4,
        C_IN_SEG   = 3'd5,
        C_BAD_PLAN = 3'd6,
        C_WAIT     = 3'd7    // divider busy or output register full
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic no_item;
        logic is_start;
        logic at_end;
        logic in_seg;
        logic bad_plan;
        logic div_busy;
        logic out_busy;
    } stat_t;

    // Microcode addresses
    localparam logic [PC_W-1:0] A_FETCH    = 4'd0;
    localparam logic [PC_W-1:0] A_DISPATCH = 4'd1;
    localparam logic [PC_W-1:0] A_CHKEND   = 4'd2;
    localparam logic [PC_W-1:0] A_CHKSEG   = 4'd3;
    localparam logic [PC_W-1:0] A_PLAN     = 4'd4;
    localparam logic [PC_W-1:0] A_DIVWAIT  = 4'd5;
    localparam logic [PC_W-1:0] A_COMMIT   = 4'd6;
    localparam logic [PC_W-1:0] A_ACCUM    = 4'd7;
    localparam logic [PC_W-1:0] A_EMIT     = 4'd8;
    localparam logic [PC_W-1:0] A_START    = 4'd9;
    localparam logic [PC_W-1:0] A_PERR     = 4'd10;
    localparam logic [PC_W-1:0] A_END      = 4'd11;
    localparam logic [PC_W-1:0] A_OUT      = 4'd12;
    localparam logic [PC_W-1:0] A_RET      = 4'd13;

    // Program: jump to target when cond holds, else fall through
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] addr);
        ctrl_word_t w;
        case (addr)
            A_FETCH:    w = '{OP_FETCH,  C_NO_ITEM,  A_FETCH};
            A_DISPATCH: w = '{OP_NOP,    C_IS_START, A_START};
            A_CHKEND:   w = '{OP_NOP,    C_AT_END,   A_END};
            A_CHKSEG:   w = '{OP_NOP,    C_IN_SEG,   A_ACCUM};
            A_PLAN:     w = '{OP_PLAN,   C_BAD_PLAN, A_PERR};
            A_DIVWAIT:  w = '{OP_NOP,    C_WAIT,     A_DIVWAIT};
            A_COMMIT:   w = '{OP_COMMIT, C_IS_START, A_OUT};
            A_ACCUM:    w = '{OP_ACCUM,  C_NEVER,    A_FETCH};
            A_EMIT:     w = '{OP_EMIT,   C_ALWAYS,   A_OUT};
            A_START:    w = '{OP_START,  C_ALWAYS,   A_PLAN};
            A_PERR:     w = '{OP_PERR,   C_ALWAYS,   A_OUT};
            A_END:      w = '{OP_END,    C_NEVER,    A_FETCH};
            A_OUT:      w = '{OP_OUT,    C_WAIT,     A_OUT};
            A_RET:      w = '{OP_NOP,    C_ALWAYS,   A_FETCH};
            default:    w = '{OP_NOP,    C_ALWAYS,   A_FETCH};
        endcase
        return w;
    endfunction

endpackage

/* sv/sid_div.sv */
// Restoring divider, one quotient bit per cycle: tick budget / step count.
// Depends on sid_pkg for widths.
module sid_div import sid_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TICK_W-1:0] dividend,
    input  logic [POS_W-1:0]  divisor,
    output logic              busy,
    output logic [TICK_W-1:0] quotient,
    output logic [POS_W-1:0]  remainder
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TICK_W-1:0]    quo_reg, quo_next;
    logic [POS_W-1:0]     rem_reg, rem_next;
    logic [POS_W-1:0]     dvs_reg, dvs_next;
    logic [POS_W+1:0]     trial;

    // shift in the next dividend bit and try the subtract
    assign trial = {1'b0, rem_reg, quo_reg[TICK_W-1]} - {2'b00, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(TICK_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!trial[POS_W+1]) begin
                rem_next = trial[POS_W-1:0];
                quo_next = {quo_reg[TICK_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[POS_W-2:0], quo_reg[TICK_W-1]};
                quo_next = {quo_reg[TICK_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* sv/sid_seq.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on sid_pkg for the ROM, control word and status types.
module sid_seq import sid_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t stat,
    output op_t   op
);

    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_word_t      cw;
    logic            taken;

    assign cw = ucode_rom(pc_reg);
    assign op = cw.op;

    // jump condition select
    always_comb begin
        case (cw.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_ITEM:  taken = stat.no_item;
            C_IS_START: taken = stat.is_start;
            C_AT_END:   taken = stat.at_end;
            C_IN_SEG:   taken = stat.in_seg;
            C_BAD_PLAN: taken = stat.bad_plan;
            C_WAIT:     taken = stat.div_busy | stat.out_busy;
            default:    taken = 1'b1;
        endcase
        pc_next = taken ? cw.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= A_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* sv/sid_dpath.sv */
// Datapath: config, tracking state, Bresenham spread and the output register.
// Depends on sid_pkg; drives sid_div and reports status to sid_seq.
module sid_dpath import sid_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  op_t               op,
    output stat_t             stat,
    // config
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [TICK_W-1:0] cfg_wdata,
    // input word
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [POS_W-1:0]  s_start_position,
    input  logic [POS_W-1:0]  s_next_target,
    // result word
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_step_valid,
    output logic [TICK_W-1:0] m_step_ticks,
    output logic              m_at_end,
    output logic              m_replanned,
    output logic              m_plan_error,
    // divider
    output logic              div_start,
    output logic [TICK_W-1:0] div_dividend,
    output logic [POS_W-1:0]  div_divisor,
    input  logic              div_busy,
    input  logic [TICK_W-1:0] div_quotient,
    input  logic [POS_W-1:0]  div_remainder
);

    logic [POS_W-1:0]        max_pos_reg;
    logic [TICK_W-1:0]       ticks_reg;

    logic                    req_reg;
    logic [POS_W-1:0]        sp_reg;
    logic [POS_W-1:0]        tgt_reg;

    logic [POS_W-1:0]        qpos_reg;
    logic [POS_W-1:0]        seg_tgt_reg;
    logic [POS_W-1:0]        seg_steps_reg;
    logic [TICK_W-1:0]       base_reg;
    logic [POS_W-1:0]        extra_reg;
    logic signed [ERR_W-1:0] err_reg;

    logic                    r_step_reg, r_end_reg, r_repl_reg, r_perr_reg;
    logic [TICK_W-1:0]       r_ticks_reg;

    logic                    m_valid_reg;
    logic                    m_step_valid_reg, m_at_end_reg, m_repl_reg, m_perr_reg;
    logic [TICK_W-1:0]       m_ticks_reg;

    logic                    accept;
    logic                    out_free;
    logic [POS_W-1:0]        diff;
    logic signed [ERR_W-1:0] steps_ext;
    logic signed [ERR_W-1:0] extra2_ext;
    logic signed [ERR_W-1:0] steps2_ext;

    assign s_ready  = (op == OP_FETCH);
    assign accept   = s_valid & s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign diff     = tgt_reg - seg_tgt_reg;

    assign steps_ext  = $signed({{(ERR_W-POS_W){1'b0}}, seg_steps_reg});
    assign extra2_ext = $signed({{(ERR_W-POS_W-1){1'b0}}, extra_reg, 1'b0});
    assign steps2_ext = $signed({{(ERR_W-POS_W-1){1'b0}}, seg_steps_reg, 1'b0});

    // status for the sequencer
    always_comb begin
        stat.no_item  = !s_valid;
        stat.is_start = (req_reg == REQ_START);
        stat.at_end   = (qpos_reg >= max_pos_reg);
        stat.in_seg   = (qpos_reg < seg_tgt_reg);
        stat.bad_plan = (tgt_reg <= seg_tgt_reg);
        stat.div_busy = div_busy;
        stat.out_busy = (op == OP_OUT) && !out_free;
    end

    // divider launch, only for a segment that lies ahead
    assign div_start    = (op == OP_PLAN) && !stat.bad_plan;
    assign div_dividend = ticks_reg;
    assign div_divisor  = diff;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pos_reg <= MAX_POS_RST;
            ticks_reg   <= TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MAX_POS: max_pos_reg <= cfg_wdata[POS_W-1:0];
                CFG_TICKS:   ticks_reg   <= cfg_wdata;
                default:     ticks_reg   <= ticks_reg;
            endcase
        end
    end

    // input word capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_req_type;
            sp_reg  <= s_start_position;
            tgt_reg <= s_next_target;
        end
    end

    // tracking state and per-item result flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qpos_reg      <= '0;
            seg_tgt_reg   <= '0;
            seg_steps_reg <= '0;
            base_reg      <= '0;
            extra_reg     <= '0;
            err_reg       <= '0;
            r_step_reg    <= 1'b0;
            r_end_reg     <= 1'b0;
            r_repl_reg    <= 1'b0;
            r_perr_reg    <= 1'b0;
            r_ticks_reg   <= '0;
        end else begin
            case (op)
                OP_FETCH: begin
                    if (accept) begin
                        r_step_reg  <= 1'b0;
                        r_end_reg   <= 1'b0;
                        r_repl_reg  <= 1'b0;
                        r_perr_reg  <= 1'b0;
                        r_ticks_reg <= '0;
                    end
                end
                OP_START: begin
                    qpos_reg    <= sp_reg;
                    seg_tgt_reg <= sp_reg;
                end
                OP_COMMIT: begin
                    seg_steps_reg <= diff;
                    base_reg      <= div_quotient;
                    extra_reg     <= div_remainder;
                    err_reg       <= '0;
                    seg_tgt_reg   <= tgt_reg;
                    r_repl_reg    <= 1'b1;
                end
                OP_ACCUM: begin
                    err_reg <= err_reg + extra2_ext;
                end
                OP_EMIT: begin
                    // overshoot: pay back two steps' worth, add one tick
                    if (err_reg > steps_ext) begin
                        err_reg     <= err_reg - steps2_ext;
                        r_ticks_reg <= base_reg + 1'b1;
                    end else begin
                        r_ticks_reg <= base_reg;
                    end
                    r_step_reg <= 1'b1;
                    qpos_reg   <= qpos_reg + 1'b1;
                end
                OP_PERR: r_perr_reg <= 1'b1;
                OP_END:  r_end_reg  <= 1'b1;
                default: r_end_reg  <= r_end_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (op == OP_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == OP_OUT && out_free) begin
            m_step_valid_reg <= r_step_reg;
            m_ticks_reg      <= r_ticks_reg;
            m_at_end_reg     <= r_end_reg;
            m_repl_reg       <= r_repl_reg;
            m_perr_reg       <= r_perr_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_step_valid = m_step_valid_reg;
    assign m_step_ticks = m_ticks_reg;
    assign m_at_end     = m_at_end_reg;
    assign m_replanned  = m_repl_reg;
    assign m_plan_error = m_perr_reg;

endmodule

/* sv/step_interval_distributor.sv */
// Top level of the step interval distributor: sequencer, datapath, divider.
// Depends on sid_pkg, sid_seq, sid_dpath and sid_div.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+--------------------------
//  config  | cfg_we, cfg_addr, cfg_wdata    | write on cfg_we, no wait
//  input   | s_req_type, s_start_position,  | s_valid / s_ready
//          | s_next_target                  |
//  result  | m_step_valid, m_step_ticks,    | m_valid / m_ready
//          | m_at_end, m_replanned,         |
//          | m_plan_error                   |
//
// One word at a time. A step inside the segment accumulates the error and
// emits an interval; an end report or a plan error goes straight to the output
// step; an item that replans waits for the divider, then commits the new plan.
// Reset (synchronous, aresetn low) returns the step counter to fetch and
// clears all tracking state. A stalled result holds in the output register;
// the sequencer waits at the output step until it frees.
module step_interval_distributor import sid_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [TICK_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [POS_W-1:0]  s_start_position,
    input  logic [POS_W-1:0]  s_next_target,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_step_valid,
    output logic [TICK_W-1:0] m_step_ticks,
    output logic              m_at_end,
    output logic              m_replanned,
    output logic              m_plan_error
);

    op_t               op;
    stat_t             stat;
    logic              div_start;
    logic              div_busy;
    logic [TICK_W-1:0] div_dividend;
    logic [POS_W-1:0]  div_divisor;
    logic [TICK_W-1:0] div_quotient;
    logic [POS_W-1:0]  div_remainder;

    sid_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .op      (op)
    );

    sid_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .op               (op),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_start_position (s_start_position),
        .s_next_target    (s_next_target),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_step_valid     (m_step_valid),
        .m_step_ticks     (m_step_ticks),
        .m_at_end         (m_at_end),
        .m_replanned      (m_replanned),
        .m_plan_error     (m_plan_error),
        .div_start        (div_start),
        .div_dividend     (div_dividend),
        .div_divisor      (div_divisor),
        .div_busy         (div_busy),
        .div_quotient     (div_quotient),
        .div_remainder    (div_remainder)
    );

    sid_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

endmodule

/* sv/sid_chk.sv */
// Port-level checker for the step interval distributor, bound to the top.
// Depends on sid_pkg for widths.
module sid_chk import sid_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_step_valid,
    input logic [TICK_W-1:0] m_step_ticks,
    input logic              m_at_end,
    input logic              m_replanned,
    input logic              m_plan_error
);

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present after reset");

    // one word in flight: no back-to-back input accepts
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is in work");

    // a stalled result word holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_step_ticks)
            && $stable(m_step_valid))
        else $error("stalled result word changed");

    // flags are exclusive where the behavior says so
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_step_valid && m_plan_error) && !(m_replanned && m_plan_error)
            && !(m_at_end && (m_step_valid || m_replanned || m_plan_error)))
        else $error("conflicting result flags");

    // no interval without a step
    a_ticks_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_step_valid) |-> (m_step_ticks == '0))
        else $error("nonzero interval without a step");

endmodule

bind step_interval_distributor sid_chk u_sid_chk (.*);
